### hdl/eul2rot_pkg.sv
// ----------------------------------------------------------------------------
// eul2rot_pkg
// Shared constants, types and the CORDIC arctangent table for the ZYX
// Euler-angle to rotation-matrix unit.
// ----------------------------------------------------------------------------
package eul2rot_pkg;

  localparam int unsigned TrigIterDefault = 16;
  localparam int unsigned OutWidthDefault = 16;
  localparam int unsigned AtanLen         = 24;

  localparam int unsigned NumAngles = 3;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned WrapW     = AngleW + 1;
  localparam int unsigned AbsW      = AngleW - 1;
  localparam int unsigned MagW      = 14;

  localparam int HalfTurn    = 23040;
  localparam int QuarterTurn = 11520;
  localparam int FullTurn    = 46080;

  localparam int unsigned ZpW        = 40;
  localparam int unsigned RadScaleQ8 = 37480660;
  localparam int unsigned RadRound   = 128;
  localparam int unsigned RadShift   = 8;

  localparam int unsigned CW           = 34;
  localparam int unsigned ScRound      = 512;
  localparam int unsigned ScShift      = 10;
  localparam int unsigned SCW          = 22;
  localparam int unsigned PW           = 2 * SCW;
  localparam int unsigned LoW          = 21;
  localparam int unsigned HiW          = PW - LoW;
  localparam int unsigned HPW          = HiW + SCW;
  localparam int unsigned LPW          = LoW + 1 + SCW;
  localparam int unsigned TW           = 64;
  localparam int unsigned OneShift     = 20;
  localparam int unsigned ProductFrac  = 61;

  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [CW-1:0]  cordic_t;
  typedef logic signed [SCW-1:0] trig_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [TW-1:0]  term_t;

  typedef struct packed {
    logic [NumAngles-1:0] neg_sin;
    logic [NumAngles-1:0] neg_cos;
  } fold_t;

  function automatic cordic_t atan_q30(input int unsigned idx);
    cordic_t val;
    case (idx)
      0:       val = 34'sd843314856;
      1:       val = 34'sd497837829;
      2:       val = 34'sd263043836;
      3:       val = 34'sd133525158;
      4:       val = 34'sd67021686;
      5:       val = 34'sd33543515;
      6:       val = 34'sd16775850;
      7:       val = 34'sd8388437;
      8:       val = 34'sd4194282;
      9:       val = 34'sd2097149;
      10:      val = 34'sd1048575;
      11:      val = 34'sd524287;
      12:      val = 34'sd262143;
      13:      val = 34'sd131071;
      14:      val = 34'sd65535;
      15:      val = 34'sd32767;
      16:      val = 34'sd16383;
      17:      val = 34'sd8191;
      18:      val = 34'sd4095;
      19:      val = 34'sd2047;
      20:      val = 34'sd1023;
      21:      val = 34'sd511;
      22:      val = 34'sd255;
      23:      val = 34'sd127;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hdl/euler_angles_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_unit
// Turns roll, pitch and yaw (1/128 degree) into the nine Q1.15 entries of
// Rz(yaw) * Ry(pitch) * Rx(roll) through a pipelined CORDIC and multipliers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries the three angles; a transfer happens on a rising
// edge with valid_i high and stall_o low. The output channel carries the nine
// matrix entries; a transfer happens with valid_o high and stall_i low.
// Any 16-bit angle is accepted and wrapped into one turn first.
// From input transfer to valid_o an item passes through angle folding,
// angle scaling, the CORDIC iteration registers, sine and cosine rounding,
// the product and rounding stages, and the output register. Throughput is
// one item per cycle while stall_o is low; every stage is a register stage.
// When the receiver stalls, one more item drains into a skid register and
// then stall_o rises for as long as that register is occupied; nothing is
// lost or repeated. Reset clears all valid bits; the pipe is empty after it.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_unit #(
  parameter int unsigned TRIG_ITERATIONS = eul2rot_pkg::TrigIterDefault,
  parameter int unsigned OUT_WIDTH       = eul2rot_pkg::OutWidthDefault
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      stall_o,
  input  logic signed [eul2rot_pkg::AngleW-1:0]     roll_angle_i,
  input  logic signed [eul2rot_pkg::AngleW-1:0]     pitch_angle_i,
  input  logic signed [eul2rot_pkg::AngleW-1:0]     yaw_angle_i,
  output logic                                      valid_o,
  input  logic                                      stall_i,
  output logic signed [OUT_WIDTH-1:0]               rotation_00_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_01_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_02_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_10_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_11_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_12_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_20_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_21_o,
  output logic signed [OUT_WIDTH-1:0]               rotation_22_o
);
  import eul2rot_pkg::*;

  localparam int unsigned NIter  = (TRIG_ITERATIONS > AtanLen) ? AtanLen : TRIG_ITERATIONS;
  localparam int unsigned NStage = NIter + 7;
  localparam int unsigned NEntry = 9;
  localparam int unsigned Shift  = ProductFrac - OUT_WIDTH;
  localparam term_t RoundT = TW'(1) <<< (Shift - 1);
  localparam term_t LimT   = (TW'(1) <<< (OUT_WIDTH - 1)) - TW'(1);
  localparam logic [OUT_WIDTH-1:0] MinOut = {1'b1, {(OUT_WIDTH - 1){1'b0}}};

  localparam int unsigned RollIdx  = 0;
  localparam int unsigned PitchIdx = 1;
  localparam int unsigned YawIdx   = 2;

  logic                        en;
  logic                        push;
  logic [NStage-1:0]           v_q;
  logic signed [AngleW-1:0]    ang [NumAngles];

  logic signed [WrapW-1:0]     wr    [NumAngles];
  logic signed [WrapW-1:0]     absw  [NumAngles];
  logic [AbsW-1:0]             mg    [NumAngles];
  logic [MagW-1:0]             mf    [NumAngles];
  fold_t                       fold;
  logic [ZpW-1:0]              zprod [NumAngles];

  logic [MagW-1:0]             m1_q  [NumAngles];
  fold_t                       fl_q  [NIter + 2];
  cordic_t                     x_q   [NIter + 1][NumAngles];
  cordic_t                     y_q   [NIter + 1][NumAngles];
  cordic_t                     z_q   [NIter + 1][NumAngles];

  cordic_t                     xr    [NumAngles];
  cordic_t                     yr    [NumAngles];
  trig_t                       sin_q [NumAngles];
  trig_t                       cos_q [NumAngles];

  prod_t spsr1_q, spcr1_q, cycp1_q, sycr1_q, sysr1_q;
  prod_t sycp1_q, cycr1_q, cysr1_q, cpsr1_q, cpcr1_q;
  trig_t sp1_q, cy1_q, sy1_q;

  logic signed [HiW-1:0]       spsr_hi, spcr_hi;
  logic signed [LoW:0]         spsr_lo, spcr_lo;
  logic signed [HPW-1:0]       cyspsr_h2_q, syspsr_h2_q, cyspcr_h2_q, syspcr_h2_q;
  logic signed [LPW-1:0]       cyspsr_l2_q, syspsr_l2_q, cyspcr_l2_q, syspcr_l2_q;
  prod_t cycp2_q, sycr2_q, sysr2_q, sycp2_q, cycr2_q, cysr2_q, cpsr2_q, cpcr2_q;
  trig_t sp2_q;

  term_t cyspsr3_q, syspsr3_q, cyspcr3_q, syspcr3_q;
  prod_t cycp3_q, sycr3_q, sysr3_q, sycp3_q, cycr3_q, cysr3_q, cpsr3_q, cpcr3_q;
  trig_t sp3_q;

  term_t                       t4_q  [NEntry];
  term_t                       qv    [NEntry];
  logic [OUT_WIDTH-1:0]        res   [NEntry];
  logic [OUT_WIDTH-1:0]        ro_q  [NEntry];
  logic [OUT_WIDTH-1:0]        sk_q  [NEntry];
  logic                        ov_q;
  logic                        skv_q;

  assign ang[RollIdx]  = roll_angle_i;
  assign ang[PitchIdx] = pitch_angle_i;
  assign ang[YawIdx]   = yaw_angle_i;

  assign en      = !skv_q;
  assign stall_o = skv_q;
  assign push    = en && v_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStage-2:0], valid_i};
    end
  end

  // Wrap into one turn, then fold the angle into the first quadrant.
  always_comb begin
    for (int a = 0; a < NumAngles; a++) begin
      wr[a] = WrapW'(ang[a]);
      if (wr[a] >= WrapW'(HalfTurn)) begin
        wr[a] = wr[a] - WrapW'(FullTurn);
      end
      if (wr[a] < -WrapW'(HalfTurn)) begin
        wr[a] = wr[a] + WrapW'(FullTurn);
      end
      fold.neg_sin[a] = wr[a][WrapW-1];
      absw[a] = wr[a][WrapW-1] ? -wr[a] : wr[a];
      mg[a] = absw[a][AbsW-1:0];
      if (int'(mg[a]) > QuarterTurn) begin
        mf[a] = MagW'(HalfTurn - int'(mg[a]));
        fold.neg_cos[a] = 1'b1;
      end else begin
        mf[a] = mg[a][MagW-1:0];
        fold.neg_cos[a] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NumAngles; a++) begin
      zprod[a] = ZpW'(m1_q[a]) * ZpW'(RadScaleQ8) + ZpW'(RadRound);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fold;
      fl_q[1] <= fl_q[0];
      for (int a = 0; a < NumAngles; a++) begin
        m1_q[a]   <= mf[a];
        x_q[0][a] <= CordicGain;
        y_q[0][a] <= '0;
        z_q[0][a] <= CW'(zprod[a] >> RadShift);
      end
    end
  end

  for (genvar j = 0; j < NIter; j++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        fl_q[j+2] <= fl_q[j+1];
        for (int a = 0; a < NumAngles; a++) begin
          if (!z_q[j][a][CW-1]) begin
            x_q[j+1][a] <= x_q[j][a] - (y_q[j][a] >>> j);
            y_q[j+1][a] <= y_q[j][a] + (x_q[j][a] >>> j);
            z_q[j+1][a] <= z_q[j][a] - atan_q30(j);
          end else begin
            x_q[j+1][a] <= x_q[j][a] + (y_q[j][a] >>> j);
            y_q[j+1][a] <= y_q[j][a] - (x_q[j][a] >>> j);
            z_q[j+1][a] <= z_q[j][a] + atan_q30(j);
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NumAngles; a++) begin
      xr[a] = (x_q[NIter][a] + CW'(ScRound)) >>> ScShift;
      yr[a] = (y_q[NIter][a] + CW'(ScRound)) >>> ScShift;
    end
  end

  assign spsr_hi = spsr1_q[PW-1:LoW];
  assign spsr_lo = {1'b0, spsr1_q[LoW-1:0]};
  assign spcr_hi = spcr1_q[PW-1:LoW];
  assign spcr_lo = {1'b0, spcr1_q[LoW-1:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NumAngles; a++) begin
        sin_q[a] <= fl_q[NIter+1].neg_sin[a] ? -yr[a][SCW-1:0] : yr[a][SCW-1:0];
        cos_q[a] <= fl_q[NIter+1].neg_cos[a] ? -xr[a][SCW-1:0] : xr[a][SCW-1:0];
      end

      spsr1_q <= PW'(sin_q[PitchIdx]) * PW'(sin_q[RollIdx]);
      spcr1_q <= PW'(sin_q[PitchIdx]) * PW'(cos_q[RollIdx]);
      cycp1_q <= PW'(cos_q[YawIdx]) * PW'(cos_q[PitchIdx]);
      sycr1_q <= PW'(sin_q[YawIdx]) * PW'(cos_q[RollIdx]);
      sysr1_q <= PW'(sin_q[YawIdx]) * PW'(sin_q[RollIdx]);
      sycp1_q <= PW'(sin_q[YawIdx]) * PW'(cos_q[PitchIdx]);
      cycr1_q <= PW'(cos_q[YawIdx]) * PW'(cos_q[RollIdx]);
      cysr1_q <= PW'(cos_q[YawIdx]) * PW'(sin_q[RollIdx]);
      cpsr1_q <= PW'(cos_q[PitchIdx]) * PW'(sin_q[RollIdx]);
      cpcr1_q <= PW'(cos_q[PitchIdx]) * PW'(cos_q[RollIdx]);
      sp1_q   <= sin_q[PitchIdx];
      cy1_q   <= cos_q[YawIdx];
      sy1_q   <= sin_q[YawIdx];

      // Three-factor products are split into two partial products.
      cyspsr_h2_q <= HPW'(spsr_hi) * HPW'(cy1_q);
      cyspsr_l2_q <= LPW'(spsr_lo) * LPW'(cy1_q);
      syspsr_h2_q <= HPW'(spsr_hi) * HPW'(sy1_q);
      syspsr_l2_q <= LPW'(spsr_lo) * LPW'(sy1_q);
      cyspcr_h2_q <= HPW'(spcr_hi) * HPW'(cy1_q);
      cyspcr_l2_q <= LPW'(spcr_lo) * LPW'(cy1_q);
      syspcr_h2_q <= HPW'(spcr_hi) * HPW'(sy1_q);
      syspcr_l2_q <= LPW'(spcr_lo) * LPW'(sy1_q);
      cycp2_q <= cycp1_q;
      sycr2_q <= sycr1_q;
      sysr2_q <= sysr1_q;
      sycp2_q <= sycp1_q;
      cycr2_q <= cycr1_q;
      cysr2_q <= cysr1_q;
      cpsr2_q <= cpsr1_q;
      cpcr2_q <= cpcr1_q;
      sp2_q   <= sp1_q;

      cyspsr3_q <= (TW'(cyspsr_h2_q) <<< LoW) + TW'(cyspsr_l2_q);
      syspsr3_q <= (TW'(syspsr_h2_q) <<< LoW) + TW'(syspsr_l2_q);
      cyspcr3_q <= (TW'(cyspcr_h2_q) <<< LoW) + TW'(cyspcr_l2_q);
      syspcr3_q <= (TW'(syspcr_h2_q) <<< LoW) + TW'(syspcr_l2_q);
      cycp3_q <= cycp2_q;
      sycr3_q <= sycr2_q;
      sysr3_q <= sysr2_q;
      sycp3_q <= sycp2_q;
      cycr3_q <= cycr2_q;
      cysr3_q <= cysr2_q;
      cpsr3_q <= cpsr2_q;
      cpcr3_q <= cpcr2_q;
      sp3_q   <= sp2_q;

      t4_q[0] <= (TW'(cycp3_q) <<< OneShift) + RoundT;
      t4_q[1] <= cyspsr3_q - (TW'(sycr3_q) <<< OneShift) + RoundT;
      t4_q[2] <= cyspcr3_q + (TW'(sysr3_q) <<< OneShift) + RoundT;
      t4_q[3] <= (TW'(sycp3_q) <<< OneShift) + RoundT;
      t4_q[4] <= syspsr3_q + (TW'(cycr3_q) <<< OneShift) + RoundT;
      t4_q[5] <= syspcr3_q - (TW'(cysr3_q) <<< OneShift) + RoundT;
      t4_q[6] <= RoundT - (TW'(sp3_q) <<< (2 * OneShift));
      t4_q[7] <= (TW'(cpsr3_q) <<< OneShift) + RoundT;
      t4_q[8] <= (TW'(cpcr3_q) <<< OneShift) + RoundT;
    end
  end

  always_comb begin
    for (int k = 0; k < NEntry; k++) begin
      qv[k] = t4_q[k] >>> Shift;
      if (qv[k] > LimT) begin
        res[k] = LimT[OUT_WIDTH-1:0];
      end else if (qv[k] < -LimT) begin
        res[k] = OUT_WIDTH'(-LimT);
      end else begin
        res[k] = qv[k][OUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      skv_q <= 1'b0;
    end else if (!ov_q || !stall_i) begin
      ov_q  <= skv_q || push;
      skv_q <= 1'b0;
    end else if (push) begin
      skv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NEntry; k++) begin
      if (!ov_q || !stall_i) begin
        ro_q[k] <= skv_q ? sk_q[k] : res[k];
      end else if (push) begin
        sk_q[k] <= res[k];
      end
    end
  end

  assign valid_o       = ov_q;
  assign rotation_00_o = ro_q[0];
  assign rotation_01_o = ro_q[1];
  assign rotation_02_o = ro_q[2];
  assign rotation_10_o = ro_q[3];
  assign rotation_11_o = ro_q[4];
  assign rotation_12_o = ro_q[5];
  assign rotation_20_o = ro_q[6];
  assign rotation_21_o = ro_q[7];
  assign rotation_22_o = ro_q[8];

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skv_q |-> ov_q)
    else $error("Skid register holds an item while the output register is empty.");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skv_q) |-> $past(ov_q && stall_i))
    else $error("Skid register filled without a stalled output.");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skv_q |=> $stable(v_q))
    else $error("Pipeline advanced while the skid register was occupied.");

  a_symmetric_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ro_q[0] != MinOut) && (ro_q[4] != MinOut) && (ro_q[6] != MinOut)
             && (ro_q[8] != MinOut))
    else $error("Matrix entry reached the most negative code.");
`endif

endmodule
